### src/lz4l_pkg.sv
// ----------------------------------------------------------------------------
// lz4l_pkg
// shared types and constants of the lz4 legacy stream decompressor
// ----------------------------------------------------------------------------
package lz4l_pkg;

	localparam int unsigned HIST_DEPTH_DEF = 65536;
	localparam logic [31:0] LZ_MAGIC = 32'h184C2102;
	localparam logic [29:0] LIMIT_RESET = 30'h2000_0000;
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration register byte addresses
	localparam logic [1:0] ADDR_OUTPUT_LIMIT = 2'd0;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_SIZE, PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI,
		PH_MATEXT, PH_COPY, PH_COPY_LAST, PH_OK, PH_EMPTY, PH_BADMAGIC, PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0, ST_OK = 3'd1, ST_EMPTY = 3'd2, ST_BADMAGIC = 3'd3, ST_ERROR = 3'd4
	} status_t;

	// classified item handed from front to back
	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	// result item
	typedef struct packed {
		logic        out_valid;
		logic [7:0]  out_byte;
		logic        block_end;
		status_t     status;
		logic        copy_pending;
		logic [29:0] total_out;
	} result_t;

endpackage

### src/lz4l_front.sv
// ----------------------------------------------------------------------------
// lz4l_front
// input acceptance and a short item queue feeding the decoder
// ----------------------------------------------------------------------------
module lz4l_front
	import lz4l_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_ready,
	output item_t q_item
);
	item_t mem_q [QUEUE_DEPTH];
	logic  wr_q, rd_q;
	logic  [1:0] cnt_q;
	logic  push, pop;

	assign in_ready = (cnt_q != 2'(QUEUE_DEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = mem_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

### src/lz4l_back.sv
// ----------------------------------------------------------------------------
// lz4l_back
// sequence decoder, history memory and output register
// ----------------------------------------------------------------------------
module lz4l_back
	import lz4l_pkg::*;
#(
	parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [29:0] output_limit,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        res_valid,
	input  logic        res_ready,
	output result_t     res
);
	localparam int unsigned HW = $clog2(HIST_DEPTH);

	phase_t      phase_q, phase_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [31:0] size_q, size_d;
	logic [31:0] bleft_q, bleft_d;
	logic [31:0] lit_q, lit_d;
	logic [31:0] mat_q, mat_d;
	logic [3:0]  nib_q, nib_d;
	logic [15:0] dist_q, dist_d;
	logic [31:0] prod_q, prod_d;
	logic [29:0] tot_q, tot_d;
	logic [HW-1:0] hptr_q, hptr_d;
	logic [7:0]  hist [HIST_DEPTH];
	logic [7:0]  rd_byte_q;

	// pull data fetch: a pull's history byte is read into a register ahead of the pull
	logic        pend_q;      // result slot busy
	logic        fetch_ok_q;  // rd_byte_q is valid for the next pull

	logic        take, emit, ended, wr_en;
	logic [7:0]  emit_byte;
	logic [31:0] room, bl1, sum;
	logic [32:0] lsum;
	logic [HW-1:0] rd_addr;

	assign room = (output_limit > tot_q) ? {2'b0, output_limit - tot_q} : 32'd0;
	assign q_ready = (!pend_q || res_ready) &&
		!((phase_q == PH_COPY || phase_q == PH_COPY_LAST) && !fetch_ok_q);
	assign take = q_valid && q_ready;
	assign bl1 = bleft_q - 32'd1;

	function automatic logic [31:0] sadd(input logic [31:0] a, input logic [7:0] b);
		logic [32:0] s;
		s = {1'b0, a} + 33'(b);
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	always_comb begin
		phase_d = phase_q; hcnt_d = hcnt_q; size_d = size_q; bleft_d = bleft_q;
		lit_d = lit_q; mat_d = mat_q; nib_d = nib_q; dist_d = dist_q;
		prod_d = prod_q; tot_d = tot_q; hptr_d = hptr_q;
		emit = 1'b0; emit_byte = 8'd0; ended = 1'b0; sum = 32'd0; lsum = 33'd0;
		if (take && phase_q < PH_OK) begin
			if (phase_q == PH_COPY || phase_q == PH_COPY_LAST) begin
				if (q_item.action) begin
					if (prod_q >= room) phase_d = PH_ERROR;
					else begin
						emit = 1'b1; emit_byte = rd_byte_q;
						hptr_d = hptr_q + HW'(1); prod_d = prod_q + 32'd1;
						mat_d = mat_q - 32'd1;
						if (mat_q == 32'd1) begin
							if (bleft_q == 32'd0) begin
								tot_d = tot_q + prod_d[29:0]; ended = 1'b1;
								hcnt_d = 2'd0; size_d = 32'd0;
								phase_d = (phase_q == PH_COPY_LAST) ?
									((tot_d != 30'd0) ? PH_OK : PH_EMPTY) : PH_SIZE;
							end else phase_d = PH_TOKEN;
						end
					end
				end
			end else if (!q_item.action) begin
				case (phase_q)
					PH_MAGIC: begin
						if (q_item.in_byte != LZ_MAGIC[8*hcnt_q +: 8]) phase_d = PH_BADMAGIC;
						else if (hcnt_q == 2'd3) begin
							phase_d = PH_SIZE; hcnt_d = 2'd0; size_d = 32'd0;
						end else hcnt_d = hcnt_q + 2'd1;
					end
					PH_SIZE: begin
						sum = size_q | (32'(q_item.in_byte) << (8*hcnt_q));
						size_d = sum;
						if (hcnt_q == 2'd3) begin
							hcnt_d = 2'd0;
							if (sum == 32'd0) phase_d = (tot_q != 30'd0) ? PH_OK : PH_EMPTY;
							else begin
								bleft_d = sum; prod_d = 32'd0; phase_d = PH_TOKEN;
							end
						end else hcnt_d = hcnt_q + 2'd1;
					end
					default: begin
						if (bleft_q == 32'd0) phase_d = PH_ERROR;
						else begin
							bleft_d = bl1;
							case (phase_q)
								PH_TOKEN, PH_LITEXT: begin
									logic chk;
									chk = 1'b0;
									if (phase_q == PH_TOKEN) begin
										nib_d = q_item.in_byte[3:0];
										if (q_item.in_byte[7:4] == 4'hF) begin
											lit_d = 32'd15;
											phase_d = (bl1 == 32'd0) ? PH_ERROR : PH_LITEXT;
										end else begin
											lit_d = 32'(q_item.in_byte[7:4]); chk = 1'b1;
										end
									end else begin
										lit_d = sadd(lit_q, q_item.in_byte);
										if (q_item.in_byte == 8'hFF) begin
											if (bl1 == 32'd0) phase_d = PH_ERROR;
										end else chk = 1'b1;
									end
									if (chk) begin
										lsum = {1'b0, prod_q} + {1'b0, lit_d};
										if (lsum > {1'b0, room} || lit_d > bl1) phase_d = PH_ERROR;
										else if (lit_d == 32'd0) begin
											if (bl1 == 32'd0) begin
												tot_d = tot_q + prod_q[29:0]; ended = 1'b1;
												phase_d = PH_SIZE; hcnt_d = 2'd0; size_d = 32'd0;
											end else phase_d = PH_OFFLO;
										end else phase_d = PH_LIT;
									end
								end
								PH_LIT: begin
									emit = 1'b1; emit_byte = q_item.in_byte;
									hptr_d = hptr_q + HW'(1); prod_d = prod_q + 32'd1;
									lit_d = lit_q - 32'd1;
									if (lit_q == 32'd1) begin
										if (bl1 == 32'd0) begin
											tot_d = tot_q + prod_d[29:0]; ended = 1'b1;
											phase_d = PH_SIZE; hcnt_d = 2'd0; size_d = 32'd0;
										end else phase_d = PH_OFFLO;
									end
								end
								PH_OFFLO: begin
									dist_d = {8'd0, q_item.in_byte};
									phase_d = (bl1 == 32'd0) ? PH_ERROR : PH_OFFHI;
								end
								PH_OFFHI: begin
									dist_d = {q_item.in_byte, dist_q[7:0]};
									if (dist_d == 16'd0 || prod_q < 32'(dist_d)) phase_d = PH_ERROR;
									else begin
										mat_d = 32'(nib_q) + 32'd4;
										if (nib_q == 4'hF) phase_d = (bl1 == 32'd0) ? PH_ERROR : PH_MATEXT;
										else phase_d = PH_COPY;
									end
								end
								PH_MATEXT: begin
									mat_d = sadd(mat_q, q_item.in_byte);
									if (q_item.in_byte == 8'hFF) begin
										if (bl1 == 32'd0) phase_d = PH_ERROR;
									end else phase_d = PH_COPY;
								end
								default: phase_d = PH_ERROR;
							endcase
						end
					end
				endcase
				if (q_item.in_last && phase_d < PH_OK) begin
					if (phase_d == PH_MAGIC) phase_d = PH_BADMAGIC;
					else if (phase_d == PH_COPY && bleft_d == 32'd0) phase_d = PH_COPY_LAST;
					else phase_d = (tot_d != 30'd0) ? PH_OK : PH_EMPTY;
				end
			end
		end
	end

	assign wr_en = emit;
	assign rd_addr = hptr_d - dist_d[HW-1:0];

	// history: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) hist[hptr_q] <= emit_byte;
		rd_byte_q <= hist[rd_addr];
	end

	// read port sees old data when reading the address just written; the fetch
	// is then retried and the next pull waits for it, which happens on distance one
	logic collide;
	assign collide = wr_en && (rd_addr == hptr_q);

	status_t st;
	always_comb begin
		case (phase_d)
			PH_OK:       st = ST_OK;
			PH_EMPTY:    st = ST_EMPTY;
			PH_BADMAGIC: st = ST_BADMAGIC;
			PH_ERROR:    st = ST_ERROR;
			default:     st = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC; hcnt_q <= 2'd0; size_q <= 32'd0; bleft_q <= 32'd0;
			lit_q <= 32'd0; mat_q <= 32'd0; nib_q <= 4'd0; dist_q <= 16'd0;
			prod_q <= 32'd0; tot_q <= 30'd0; hptr_q <= '0;
			pend_q <= 1'b0; fetch_ok_q <= 1'b0;
		end else begin
			phase_q <= phase_d; hcnt_q <= hcnt_d; size_q <= size_d; bleft_q <= bleft_d;
			lit_q <= lit_d; mat_q <= mat_d; nib_q <= nib_d; dist_q <= dist_d;
			prod_q <= prod_d; tot_q <= tot_d; hptr_q <= hptr_d;
			fetch_ok_q <= !collide;
			if (take) pend_q <= 1'b1;
			else if (res_ready) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res.out_valid    <= emit;
			res.out_byte     <= emit_byte;
			res.block_end    <= ended;
			res.status       <= st;
			res.copy_pending <= (phase_d == PH_COPY || phase_d == PH_COPY_LAST);
			res.total_out    <= tot_d;
		end
	end

	assign res_valid = pend_q;
endmodule

### src/lz4_legacy_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lz4_legacy_stream_decompressor
// lz4 legacy-frame decoder, one compressed byte or one match byte per item
// ----------------------------------------------------------------------------
// path: an accepted item is written into the two-entry queue, is decoded by the
//   back end and its result is registered
// throughput: one item per cycle while the output is not stalled, set by the
//   decoder state update; a pull right after writing the byte it copies
//   (distance one) stalls for a retry on the single history read port
// reset: arst_n clears all control state; history is not cleared
module lz4_legacy_stream_decompressor
	import lz4l_pkg::*;
#(
	parameter int unsigned HIST_DEPTH = HIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] in_byte
	input  logic        s_axis_tlast,  // in_last
	input  logic        s_axis_tuser,  // action
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // out_valid, out_byte, block_end, status,
	                                   // copy_pending, total_out, zero fill
);
	logic [29:0] limit_q;
	item_t       in_item, q_item;
	logic        q_valid, q_ready;
	result_t     res;

	// only one register, at byte address zero
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_OUTPUT_LIMIT) ? {2'b0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= LIMIT_RESET;
		else if (psel && penable && pwrite && paddr == ADDR_OUTPUT_LIMIT)
			limit_q <= pwdata[29:0];
	end

	assign in_item = '{action: s_axis_tuser, in_byte: s_axis_tdata, in_last: s_axis_tlast};

	// front end: accept and queue items
	lz4l_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item,
		.q_valid, .q_ready, .q_item
	);

	// back end: decode, history copy, result register
	lz4l_back #(.HIST_DEPTH(HIST_DEPTH)) u_back (
		.clk, .arst_n, .output_limit(limit_q),
		.q_valid, .q_ready, .q_item,
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res
	);

	assign m_axis_tdata = {4'd0, res.total_out, res.copy_pending, res.status,
		res.block_end, res.out_byte, res.out_valid};
endmodule

### src/lz4l_checker.sv
// ----------------------------------------------------------------------------
// lz4l_checker
// port-level assertions for the decompressor
// ----------------------------------------------------------------------------
module lz4l_checker
	import lz4l_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        pready
);
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
	// no byte means byte zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("byte without valid");
	// block end never with an error status
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[12:10] != ST_ERROR &&
		m_axis_tdata[12:10] != ST_BADMAGIC)
		else $error("block end with error");
	a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind lz4_legacy_stream_decompressor lz4l_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .pready
);
